[design/mfc_pkg.sv]
// Shared types and constants for the moving feature classifier.
// Used by mfc_warp and moving_feature_classifier; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mfc_pkg;

    // Result class codes; code 3 is unused.
    typedef enum logic [1:0] {
        CLS_NONE     = 2'd0,
        CLS_MOVER    = 2'd1,
        CLS_PARALLAX = 2'd2
    } mfc_class_t;

    // Configuration register indexes
    typedef enum logic [2:0] {
        REG_COEF_PAIR_0    = 3'd0,
        REG_COEF_PAIR_1    = 3'd1,
        REG_COEF_PAIR_2    = 3'd2,
        REG_COEF_PAIR_3    = 3'd3,
        REG_COEF_LAST      = 3'd4,
        REG_SPEED_BOUNDS   = 3'd5,
        REG_FRAME_INTERVAL = 3'd6,
        REG_TRANSFORM_GOOD = 3'd7
    } mfc_reg_t;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 64;

    // Register reset values
    localparam logic [63:0] RST_COEF_PAIR_0    = 64'd16777216;
    localparam logic [63:0] RST_COEF_PAIR_1    = 64'd0;
    localparam logic [63:0] RST_COEF_PAIR_2    = 64'd16777216;
    localparam logic [63:0] RST_COEF_PAIR_3    = 64'd0;
    localparam logic [31:0] RST_COEF_LAST      = 32'd16777216;
    localparam logic [63:0] RST_SPEED_BOUNDS   = 64'd1441150506402578;
    localparam logic [31:0] RST_FRAME_INTERVAL = 32'd16777216;

    // Side information that travels with each transaction
    typedef struct packed {
        logic signed [31:0] cx;
        logic signed [31:0] cy;
        logic               par;
        logic               fend;
        logic               active;
    } mfc_side_t;

    // Side information through the warp divider
    typedef struct packed {
        mfc_side_t side;
        logic      neg_x;
        logic      neg_y;
        logic      cap_x;
        logic      cap_y;
    } mfc_side1_t;

    // Side information through the velocity divider
    typedef struct packed {
        mfc_side_t side;
        logic      neg_x;
        logic      neg_y;
        logic      sat_x;
        logic      sat_y;
    } mfc_side2_t;

endpackage

`default_nettype wire

[design/moving_feature_classifier.sv]
// Top level: configuration registers, warp rows, two dividers, speed test.
// Depends on mfc_pkg, mfc_warp and mfc_div.
//
// Usage:
//   Input channel s_*: one matched feature pair per transaction (previous
//   and current point, parallax flag, frame end mark). Result channel m_*:
//   exactly one result per input, in order.
//   Configuration channel cfg_*: always ready; write only while idle.
//   Throughput: one transaction per cycle while the receiver does not stall.
//   Pipeline: 2 warp stages, 32 stages of the warp divider (a load stage,
//   then 2 quotient bits in each of 31), 17 of the velocity divider, a
//   squaring stage and the output register.
//   Reset (aresetn low, synchronous) empties the pipeline, loads the
//   register defaults and restarts the first-frame blanking.
//   When the receiver stalls, stages fill up behind the output register
//   and s_ready drops only once every stage holds a transaction.
`timescale 1ns / 1ps
`default_nettype none

module moving_feature_classifier import mfc_pkg::*; #(
    parameter int FRAC_BITS = 24
) (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   s_valid,
    output logic                        s_ready,
    input  wire logic signed [31:0]     s_prev_x,
    input  wire logic signed [31:0]     s_prev_y,
    input  wire logic signed [31:0]     s_curr_x,
    input  wire logic signed [31:0]     s_curr_y,
    input  wire logic                   s_parallax_moving,
    input  wire logic                   s_frame_end,
    output logic                        m_valid,
    input  wire logic                   m_ready,
    output logic [1:0]                  m_feature_class,
    output logic signed [31:0]          m_pos_x,
    output logic signed [31:0]          m_pos_y,
    output logic signed [31:0]          m_vel_x,
    output logic signed [31:0]          m_vel_y,
    output logic                        m_frame_done,
    output logic                        m_frame_has_movers,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int SUM_W  = 66 - FRAC_BITS;
    localparam int N1_W   = SUM_W + FRAC_BITS;
    localparam int Q1_W   = 62;
    localparam int N2_W   = 64 + FRAC_BITS;
    localparam int D2_W   = 32;
    localparam int Q2_W   = 32;
    localparam int STEP_W = 2;

    // Configuration registers
    logic [63:0] coef_pair_reg [4];
    logic [31:0] coef_last_reg;
    logic [63:0] speed_bounds_reg;
    logic signed [31:0] frame_interval_reg;
    logic        tgood_reg;
    logic        ffd_reg;
    logic        mover_seen_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coef_pair_reg[0]   <= RST_COEF_PAIR_0;
            coef_pair_reg[1]   <= RST_COEF_PAIR_1;
            coef_pair_reg[2]   <= RST_COEF_PAIR_2;
            coef_pair_reg[3]   <= RST_COEF_PAIR_3;
            coef_last_reg      <= RST_COEF_LAST;
            speed_bounds_reg   <= RST_SPEED_BOUNDS;
            frame_interval_reg <= RST_FRAME_INTERVAL;
            tgood_reg          <= 1'b0;
        end else if (cfg_valid) begin
            unique case (mfc_reg_t'(cfg_index))
                REG_COEF_PAIR_0:    coef_pair_reg[0]   <= cfg_data;
                REG_COEF_PAIR_1:    coef_pair_reg[1]   <= cfg_data;
                REG_COEF_PAIR_2:    coef_pair_reg[2]   <= cfg_data;
                REG_COEF_PAIR_3:    coef_pair_reg[3]   <= cfg_data;
                REG_COEF_LAST:      coef_last_reg      <= cfg_data[31:0];
                REG_SPEED_BOUNDS:   speed_bounds_reg   <= cfg_data;
                REG_FRAME_INTERVAL: frame_interval_reg <= cfg_data[31:0];
                REG_TRANSFORM_GOOD: tgood_reg          <= cfg_data[0];
                default: ;
            endcase
        end
    end

    logic [8:0][31:0] coef;
    assign coef = {coef_last_reg,
                   coef_pair_reg[3][63:32], coef_pair_reg[3][31:0],
                   coef_pair_reg[2][63:32], coef_pair_reg[2][31:0],
                   coef_pair_reg[1][63:32], coef_pair_reg[1][31:0],
                   coef_pair_reg[0][63:32], coef_pair_reg[0][31:0]};

    // First-frame blanking: set once the first frame end is accepted
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ffd_reg <= 1'b0;
        end else if (s_valid && s_ready && s_frame_end) begin
            ffd_reg <= 1'b1;
        end
    end

    mfc_side_t in_side;
    assign in_side = '{cx: s_curr_x, cy: s_curr_y, par: s_parallax_moving,
                       fend: s_frame_end, active: ffd_reg && tgood_reg};

    // Warp rows
    logic                    w_valid, w_ready;
    logic signed [SUM_W-1:0] w_nx, w_ny, w_den;
    mfc_side_t               w_side;

    mfc_warp #(.FRAC_BITS(FRAC_BITS), .SUM_W(SUM_W)) u_warp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_px     (s_prev_x),
        .in_py     (s_prev_y),
        .in_side   (in_side),
        .coef      (coef),
        .out_valid (w_valid),
        .out_ready (w_ready),
        .out_nx    (w_nx),
        .out_ny    (w_ny),
        .out_den   (w_den),
        .out_side  (w_side)
    );

    // Sign and magnitude for the projective divide; zero denominator gives 0
    logic [SUM_W-1:0]          mag_nx, mag_ny, mag_den;
    logic [1:0][N1_W-1:0]      d1_num;
    logic [1:0][SUM_W-1:0]     d1_den;
    mfc_side1_t                d1_sb_in;
    logic                      den_zero;

    always_comb begin
        mag_nx   = w_nx[SUM_W-1]  ? SUM_W'(-w_nx)  : SUM_W'(w_nx);
        mag_ny   = w_ny[SUM_W-1]  ? SUM_W'(-w_ny)  : SUM_W'(w_ny);
        mag_den  = w_den[SUM_W-1] ? SUM_W'(-w_den) : SUM_W'(w_den);
        den_zero = (w_den == '0);
        if (den_zero) begin
            d1_num = '0;
            d1_den = {SUM_W'(1), SUM_W'(1)};
        end else begin
            d1_num[0] = N1_W'(mag_nx) << FRAC_BITS;
            d1_num[1] = N1_W'(mag_ny) << FRAC_BITS;
            d1_den    = {mag_den, mag_den};
        end
        d1_sb_in.side  = w_side;
        d1_sb_in.neg_x = w_nx[SUM_W-1] ^ w_den[SUM_W-1];
        d1_sb_in.neg_y = w_ny[SUM_W-1] ^ w_den[SUM_W-1];
        d1_sb_in.cap_x = (d1_num[0] >> Q1_W) >= N1_W'(d1_den[0]);
        d1_sb_in.cap_y = (d1_num[1] >> Q1_W) >= N1_W'(d1_den[1]);
    end

    logic                  d1_valid, d1_ready;
    logic [1:0][Q1_W-1:0]  d1_quo;
    logic [$bits(mfc_side1_t)-1:0] d1_sb_out;

    mfc_div #(
        .NUM_W(N1_W), .DEN_W(SUM_W), .Q_W(Q1_W), .STEP_W(STEP_W),
        .SB_W($bits(mfc_side1_t))
    ) u_div_warp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (w_valid),
        .in_ready  (w_ready),
        .in_num    (d1_num),
        .in_den    (d1_den),
        .in_sb     (d1_sb_in),
        .out_valid (d1_valid),
        .out_ready (d1_ready),
        .out_quo   (d1_quo),
        .out_sb    (d1_sb_out)
    );

    // Difference to the warped point, then sign and magnitude over the interval
    mfc_side1_t            d1_sb;
    logic [63:0]           wmag_x, wmag_y;
    logic signed [63:0]    diff_x, diff_y;
    logic [63:0]           dmag_x, dmag_y;
    logic [D2_W-1:0]       dt_eff;
    logic [1:0][N2_W-1:0]  d2_num;
    logic [1:0][D2_W-1:0]  d2_den;
    mfc_side2_t            d2_sb_in;

    always_comb begin
        d1_sb  = mfc_side1_t'(d1_sb_out);
        wmag_x = d1_sb.cap_x ? (64'd1 << Q1_W) : 64'(d1_quo[0]);
        wmag_y = d1_sb.cap_y ? (64'd1 << Q1_W) : 64'(d1_quo[1]);
        diff_x = d1_sb.neg_x ? 64'(d1_sb.side.cx) + $signed(wmag_x)
                             : 64'(d1_sb.side.cx) - $signed(wmag_x);
        diff_y = d1_sb.neg_y ? 64'(d1_sb.side.cy) + $signed(wmag_y)
                             : 64'(d1_sb.side.cy) - $signed(wmag_y);
        dmag_x = diff_x[63] ? 64'(-diff_x) : 64'(diff_x);
        dmag_y = diff_y[63] ? 64'(-diff_y) : 64'(diff_y);
        dt_eff = (frame_interval_reg <= 0) ? (D2_W'(1) << FRAC_BITS)
                                           : D2_W'(frame_interval_reg);
        d2_num[0] = N2_W'(dmag_x) << FRAC_BITS;
        d2_num[1] = N2_W'(dmag_y) << FRAC_BITS;
        d2_den    = {dt_eff, dt_eff};
        d2_sb_in.side  = d1_sb.side;
        d2_sb_in.neg_x = diff_x[63];
        d2_sb_in.neg_y = diff_y[63];
        d2_sb_in.sat_x = (d2_num[0] >> Q2_W) >= N2_W'(dt_eff);
        d2_sb_in.sat_y = (d2_num[1] >> Q2_W) >= N2_W'(dt_eff);
    end

    logic                  d2_valid, d2_ready;
    logic [1:0][Q2_W-1:0]  d2_quo;
    logic [$bits(mfc_side2_t)-1:0] d2_sb_out;

    mfc_div #(
        .NUM_W(N2_W), .DEN_W(D2_W), .Q_W(Q2_W), .STEP_W(STEP_W),
        .SB_W($bits(mfc_side2_t))
    ) u_div_vel (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (d1_valid),
        .in_ready  (d1_ready),
        .in_num    (d2_num),
        .in_den    (d2_den),
        .in_sb     (d2_sb_in),
        .out_valid (d2_valid),
        .out_ready (d2_ready),
        .out_quo   (d2_quo),
        .out_sb    (d2_sb_out)
    );

    // Saturate the velocity to 32 bits and take its magnitude for squaring
    mfc_side2_t         d2_sb;
    logic signed [31:0] vel_x, vel_y;
    logic [31:0]        mag_vx, mag_vy;

    always_comb begin
        d2_sb = mfc_side2_t'(d2_sb_out);
        if (d2_sb.sat_x || d2_quo[0][31]) begin
            vel_x = d2_sb.neg_x ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            vel_x = d2_sb.neg_x ? -$signed(d2_quo[0]) : $signed(d2_quo[0]);
        end
        if (d2_sb.sat_y || d2_quo[1][31]) begin
            vel_y = d2_sb.neg_y ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            vel_y = d2_sb.neg_y ? -$signed(d2_quo[1]) : $signed(d2_quo[1]);
        end
        mag_vx = vel_x[31] ? 32'(-vel_x) : 32'(vel_x);
        mag_vy = vel_y[31] ? 32'(-vel_y) : 32'(vel_y);
    end

    // Squaring stage
    logic               sq_vld_reg, sq_rdy, out_rdy;
    logic [63:0]        sqx_reg, sqy_reg, flsq_reg, cesq_reg;
    logic signed [31:0] vx_reg, vy_reg;
    mfc_side_t          sq_side_reg;

    assign out_rdy  = !m_valid || m_ready;
    assign sq_rdy   = !sq_vld_reg || out_rdy;
    assign d2_ready = sq_rdy;

    always_ff @(posedge aclk) begin
        if (sq_rdy && d2_valid) begin
            sqx_reg     <= mag_vx * mag_vx;
            sqy_reg     <= mag_vy * mag_vy;
            flsq_reg    <= speed_bounds_reg[31:0] * speed_bounds_reg[31:0];
            cesq_reg    <= speed_bounds_reg[63:32] * speed_bounds_reg[63:32];
            vx_reg      <= vel_x;
            vy_reg      <= vel_y;
            sq_side_reg <= d2_sb.side;
        end
    end

    // Speed window test and class
    logic [64:0]  speed_sq;
    logic         in_window;
    mfc_class_t   cls_next;
    logic         fhm_next;
    logic         mover_seen_next;

    always_comb begin
        speed_sq  = 65'(sqx_reg) + 65'(sqy_reg);
        in_window = (speed_sq > 65'(flsq_reg)) && (speed_sq < 65'(cesq_reg));
        if (sq_side_reg.active && in_window) begin
            cls_next = sq_side_reg.par ? CLS_MOVER : CLS_PARALLAX;
        end else begin
            cls_next = CLS_NONE;
        end
        fhm_next = sq_side_reg.fend && (mover_seen_reg || cls_next == CLS_MOVER);
        priority if (sq_side_reg.fend) begin
            mover_seen_next = 1'b0;
        end else if (cls_next == CLS_MOVER) begin
            mover_seen_next = 1'b1;
        end else begin
            mover_seen_next = mover_seen_reg;
        end
    end

    logic m_valid_reg;
    logic [1:0] cls_reg;
    logic signed [31:0] pos_x_reg, pos_y_reg, vel_x_reg, vel_y_reg;
    logic fdone_reg, fhm_reg;

    // Control: valid bits and the per-frame mover flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sq_vld_reg     <= 1'b0;
            m_valid_reg    <= 1'b0;
            mover_seen_reg <= 1'b0;
        end else begin
            if (sq_rdy)  sq_vld_reg  <= d2_valid;
            if (out_rdy) m_valid_reg <= sq_vld_reg;
            if (out_rdy && sq_vld_reg) mover_seen_reg <= mover_seen_next;
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (out_rdy && sq_vld_reg) begin
            cls_reg   <= cls_next;
            pos_x_reg <= sq_side_reg.cx;
            pos_y_reg <= sq_side_reg.cy;
            vel_x_reg <= sq_side_reg.active ? vx_reg : 32'sd0;
            vel_y_reg <= sq_side_reg.active ? vy_reg : 32'sd0;
            fdone_reg <= sq_side_reg.fend;
            fhm_reg   <= fhm_next;
        end
    end

    assign m_valid            = m_valid_reg;
    assign m_feature_class    = cls_reg;
    assign m_pos_x            = pos_x_reg;
    assign m_pos_y            = pos_y_reg;
    assign m_vel_x            = vel_x_reg;
    assign m_vel_y            = vel_y_reg;
    assign m_frame_done       = fdone_reg;
    assign m_frame_has_movers = fhm_reg;

endmodule

`default_nettype wire

[design/mfc_warp.sv]
// Homography numerator and denominator rows, two pipeline stages.
// Depends on mfc_pkg for the side information type.
`timescale 1ns / 1ps
`default_nettype none

module mfc_warp import mfc_pkg::*; #(
    parameter int FRAC_BITS = 24,
    parameter int SUM_W     = 66 - FRAC_BITS
) (
    input  wire logic                    aclk,
    input  wire logic                    aresetn,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic signed [31:0]      in_px,
    input  wire logic signed [31:0]      in_py,
    input  wire mfc_side_t               in_side,
    input  wire logic [8:0][31:0]        coef,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic signed [SUM_W-1:0]      out_nx,
    output logic signed [SUM_W-1:0]      out_ny,
    output logic signed [SUM_W-1:0]      out_den,
    output mfc_side_t                    out_side
);

    logic               prod_vld_reg;
    logic signed [63:0] prod_reg [6];
    mfc_side_t          prod_side_reg;
    logic               sum_vld_reg;
    logic signed [SUM_W-1:0] nx_reg, ny_reg, den_reg;
    mfc_side_t          sum_side_reg;
    logic               prod_rdy, sum_rdy;
    logic signed [63:0] shr [6];
    logic signed [63:0] nx_next, ny_next, den_next;

    assign sum_rdy  = !sum_vld_reg || out_ready;
    assign prod_rdy = !prod_vld_reg || sum_rdy;
    assign in_ready = prod_rdy;

    // Stage valid bits
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prod_vld_reg <= 1'b0;
            sum_vld_reg  <= 1'b0;
        end else begin
            if (prod_rdy) prod_vld_reg <= in_valid;
            if (sum_rdy)  sum_vld_reg  <= prod_vld_reg;
        end
    end

    // Form the six coefficient products
    always_ff @(posedge aclk) begin
        if (prod_rdy && in_valid) begin
            prod_reg[0]   <= $signed(coef[0]) * in_px;
            prod_reg[1]   <= $signed(coef[1]) * in_py;
            prod_reg[2]   <= $signed(coef[3]) * in_px;
            prod_reg[3]   <= $signed(coef[4]) * in_py;
            prod_reg[4]   <= $signed(coef[6]) * in_px;
            prod_reg[5]   <= $signed(coef[7]) * in_py;
            prod_side_reg <= in_side;
        end
    end

    // Floor-shift each product and add the constant column
    always_comb begin
        for (int i = 0; i < 6; i++) begin
            shr[i] = prod_reg[i] >>> FRAC_BITS;
        end
        nx_next  = shr[0] + shr[1] + 64'($signed(coef[2]));
        ny_next  = shr[2] + shr[3] + 64'($signed(coef[5]));
        den_next = shr[4] + shr[5] + 64'($signed(coef[8]));
    end

    always_ff @(posedge aclk) begin
        if (sum_rdy && prod_vld_reg) begin
            nx_reg       <= SUM_W'(nx_next);
            ny_reg       <= SUM_W'(ny_next);
            den_reg      <= SUM_W'(den_next);
            sum_side_reg <= prod_side_reg;
        end
    end

    assign out_valid = sum_vld_reg;
    assign out_nx    = nx_reg;
    assign out_ny    = ny_reg;
    assign out_den   = den_reg;
    assign out_side  = sum_side_reg;

endmodule

`default_nettype wire

[design/mfc_div.sv]
// Two-lane pipelined restoring divider, STEP_W quotient bits per stage.
// Caller guarantees num >> Q_W is below den. No package dependencies.
`timescale 1ns / 1ps
`default_nettype none

module mfc_div #(
    parameter int NUM_W  = 66,
    parameter int DEN_W  = 42,
    parameter int Q_W    = 62,
    parameter int STEP_W = 2,
    parameter int SB_W   = 8
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire logic [1:0][NUM_W-1:0] in_num,
    input  wire logic [1:0][DEN_W-1:0] in_den,
    input  wire logic [SB_W-1:0]       in_sb,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output logic [1:0][Q_W-1:0]        out_quo,
    output logic [SB_W-1:0]            out_sb
);

    localparam int NSTG = Q_W / STEP_W;

    logic [NSTG:0]             vld_reg;
    logic [NSTG:0]             rdy;
    logic [1:0][DEN_W-1:0]     rem_reg [NSTG+1];
    logic [1:0][Q_W-1:0]       low_reg [NSTG+1];
    logic [1:0][Q_W-1:0]       quo_reg [NSTG+1];
    logic [1:0][DEN_W-1:0]     den_reg [NSTG+1];
    logic [SB_W-1:0]           sb_reg  [NSTG+1];
    logic [1:0][DEN_W-1:0]     rem_next [NSTG];
    logic [1:0][Q_W-1:0]       low_next [NSTG];
    logic [1:0][Q_W-1:0]       quo_next [NSTG];

    // Each stage advances when empty or when the one after it advances
    assign rdy[NSTG] = !vld_reg[NSTG] || out_ready;
    genvar k;
    generate
        for (k = 0; k < NSTG; k++) begin : g_rdy
            assign rdy[k] = !vld_reg[k] || rdy[k+1];
        end
    endgenerate
    assign in_ready = rdy[0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg <= '0;
        end else begin
            if (rdy[0]) vld_reg[0] <= in_valid;
            for (int s = 1; s <= NSTG; s++) begin
                if (rdy[s]) vld_reg[s] <= vld_reg[s-1];
            end
        end
    end

    // Load the partial remainder and the bits still to bring down
    always_ff @(posedge aclk) begin
        if (rdy[0] && in_valid) begin
            for (int l = 0; l < 2; l++) begin
                rem_reg[0][l] <= DEN_W'(in_num[l] >> Q_W);
                low_reg[0][l] <= in_num[l][Q_W-1:0];
                quo_reg[0][l] <= '0;
                den_reg[0][l] <= in_den[l];
            end
            sb_reg[0] <= in_sb;
        end
    end

    generate
        for (k = 1; k <= NSTG; k++) begin : g_stage
            // Bring down STEP_W bits, subtract where the divisor fits
            always_comb begin
                logic [DEN_W:0]   t;
                logic [DEN_W-1:0] r;
                logic [Q_W-1:0]   lo;
                logic [Q_W-1:0]   q;
                for (int l = 0; l < 2; l++) begin
                    r  = rem_reg[k-1][l];
                    lo = low_reg[k-1][l];
                    q  = quo_reg[k-1][l];
                    for (int j = 0; j < STEP_W; j++) begin
                        t  = {r, lo[Q_W-1]};
                        lo = lo << 1;
                        if (t >= {1'b0, den_reg[k-1][l]}) begin
                            r = DEN_W'(t - {1'b0, den_reg[k-1][l]});
                            q = {q[Q_W-2:0], 1'b1};
                        end else begin
                            r = t[DEN_W-1:0];
                            q = {q[Q_W-2:0], 1'b0};
                        end
                    end
                    rem_next[k-1][l] = r;
                    low_next[k-1][l] = lo;
                    quo_next[k-1][l] = q;
                end
            end

            always_ff @(posedge aclk) begin
                if (rdy[k] && vld_reg[k-1]) begin
                    rem_reg[k] <= rem_next[k-1];
                    low_reg[k] <= low_next[k-1];
                    quo_reg[k] <= quo_next[k-1];
                    den_reg[k] <= den_reg[k-1];
                    sb_reg[k]  <= sb_reg[k-1];
                end
            end
        end
    endgenerate

    assign out_valid = vld_reg[NSTG];
    assign out_quo   = quo_reg[NSTG];
    assign out_sb    = sb_reg[NSTG];

endmodule

`default_nettype wire

[tb/sv/tb.sv]
// Self-checking testbench for moving_feature_classifier: directed corner cases,
// then random feature streams under several idle/stall patterns.
// Depends on mfc_pkg and the moving_feature_classifier RTL only.
`timescale 1ns / 1ps

module tb import mfc_pkg::*; ();

    localparam int FRAC = 24;
    localparam longint ONE = 64'sd1 << FRAC;
    localparam longint QCAP = 64'sd1 << 62;

    typedef struct {
        logic signed [31:0] px, py, cx, cy;
        logic               par, fend;
    } pair_t;

    typedef struct {
        mfc_class_t         cls;
        logic signed [31:0] pos_x, pos_y, vel_x, vel_y;
        logic               done, movers;
    } class_result_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    logic signed [31:0] s_prev_x = '0, s_prev_y = '0, s_curr_x = '0, s_curr_y = '0;
    logic s_parallax_moving = 1'b0, s_frame_end = 1'b0;
    logic m_valid;
    logic m_ready = 1'b0;
    logic [1:0] m_feature_class;
    logic signed [31:0] m_pos_x, m_pos_y, m_vel_x, m_vel_y;
    logic m_frame_done, m_frame_has_movers;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    moving_feature_classifier u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_prev_x(s_prev_x), .s_prev_y(s_prev_y),
        .s_curr_x(s_curr_x), .s_curr_y(s_curr_y),
        .s_parallax_moving(s_parallax_moving), .s_frame_end(s_frame_end),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_feature_class(m_feature_class),
        .m_pos_x(m_pos_x), .m_pos_y(m_pos_y),
        .m_vel_x(m_vel_x), .m_vel_y(m_vel_y),
        .m_frame_done(m_frame_done), .m_frame_has_movers(m_frame_has_movers),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Shadow copy of the register file and frame state
    logic [63:0]        coef_pair [0:3];
    logic signed [31:0] coef_h22;
    logic [63:0]        bounds;
    logic signed [31:0] interval;
    logic               xform_good;
    logic               first_frame_seen;
    logic               frame_mover;

    class_result_t pending_results[$];
    int errors = 0;
    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int n_mover = 0, n_parallax = 0, n_none = 0, n_frames = 0;

    // Floor of v / 2^FRAC
    function automatic longint floor_shift(longint v);
        return v >>> FRAC;
    endfunction

    // n * 2^FRAC / d toward zero, magnitude capped at 2^62
    function automatic longint scaled_div(longint n, longint d);
        logic [63:0]  nm, dm;
        logic [127:0] q;
        nm = (n < 0) ? 64'(-n) : 64'(n);
        dm = (d < 0) ? 64'(-d) : 64'(d);
        q = ({64'd0, nm} << FRAC) / {64'd0, dm};
        if (q > 128'(QCAP)) q = 128'(QCAP);
        return ((n < 0) != (d < 0)) ? -longint'(q[63:0]) : longint'(q[63:0]);
    endfunction

    function automatic longint sat32(longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    function automatic logic [63:0] square_mag(longint v);
        logic [63:0] m;
        m = (v < 0) ? 64'(-v) : 64'(v);
        return m * m;
    endfunction

    function automatic longint word(logic [63:0] v, int hi);
        return hi ? longint'($signed(v[63:32])) : longint'($signed(v[31:0]));
    endfunction

    // Expected result of one pair; advances the frame state
    function automatic class_result_t classify_pair(pair_t p);
        class_result_t r;
        longint nx, ny, den, wx, wy, dt, vx, vy;
        logic [63:0] fl, ce, s;
        r.cls = CLS_NONE;
        vx = 0;
        vy = 0;
        if (first_frame_seen && xform_good) begin
            nx = floor_shift(word(coef_pair[0], 0) * p.px)
               + floor_shift(word(coef_pair[0], 1) * p.py) + word(coef_pair[1], 0);
            ny = floor_shift(word(coef_pair[1], 1) * p.px)
               + floor_shift(word(coef_pair[2], 0) * p.py) + word(coef_pair[2], 1);
            den = floor_shift(word(coef_pair[3], 0) * p.px)
                + floor_shift(word(coef_pair[3], 1) * p.py) + longint'(coef_h22);
            wx = 0;
            wy = 0;
            if (den != 0) begin
                wx = scaled_div(nx, den);
                wy = scaled_div(ny, den);
            end
            dt = (interval <= 0) ? ONE : longint'(interval);
            vx = sat32(scaled_div(longint'(p.cx) - wx, dt));
            vy = sat32(scaled_div(longint'(p.cy) - wy, dt));
            fl = {32'd0, bounds[31:0]};
            ce = {32'd0, bounds[63:32]};
            s = square_mag(vx) + square_mag(vy);
            if (s > fl * fl && s < ce * ce) begin
                if (p.par) begin
                    r.cls = CLS_MOVER;
                    frame_mover = 1'b1;
                end else begin
                    r.cls = CLS_PARALLAX;
                end
            end
        end
        r.pos_x = p.cx;
        r.pos_y = p.cy;
        r.vel_x = vx[31:0];
        r.vel_y = vy[31:0];
        r.done = p.fend;
        r.movers = p.fend && frame_mover;
        if (p.fend) begin
            frame_mover = 1'b0;
            first_frame_seen = 1'b1;
        end
        return r;
    endfunction

    // Receiver: random backpressure, changed at the falling edge
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(99) >= receiver_stall_pct);
    end

    // Compare each result transaction with the oldest expectation
    always @(posedge aclk) begin
        class_result_t e;
        if (aresetn && m_valid && m_ready) begin
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result transaction class=%0d", $time,
                         m_feature_class);
                errors++;
            end else begin
                e = pending_results.pop_front();
                if (m_feature_class !== e.cls) begin
                    $display("%0t: class exp %0d got %0d", $time, e.cls, m_feature_class);
                    errors++;
                end
                if (m_pos_x !== e.pos_x || m_pos_y !== e.pos_y) begin
                    $display("%0t: pos exp (%0d,%0d) got (%0d,%0d)", $time,
                             e.pos_x, e.pos_y, m_pos_x, m_pos_y);
                    errors++;
                end
                if (m_vel_x !== e.vel_x || m_vel_y !== e.vel_y) begin
                    $display("%0t: vel exp (%0d,%0d) got (%0d,%0d)", $time,
                             e.vel_x, e.vel_y, m_vel_x, m_vel_y);
                    errors++;
                end
                if (m_frame_done !== e.done || m_frame_has_movers !== e.movers) begin
                    $display("%0t: frame flags exp %b%b got %b%b", $time,
                             e.done, e.movers, m_frame_done, m_frame_has_movers);
                    errors++;
                end
                case (e.cls)
                    CLS_MOVER:    n_mover++;
                    CLS_PARALLAX: n_parallax++;
                    default:      n_none++;
                endcase
                if (e.done) n_frames++;
            end
        end
    end

    // Write one register over the config channel; called at a falling edge
    task automatic write_reg(mfc_reg_t idx, logic [63:0] value);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        case (idx)
            REG_COEF_PAIR_0:    coef_pair[0] = value;
            REG_COEF_PAIR_1:    coef_pair[1] = value;
            REG_COEF_PAIR_2:    coef_pair[2] = value;
            REG_COEF_PAIR_3:    coef_pair[3] = value;
            REG_COEF_LAST:      coef_h22 = value[31:0];
            REG_SPEED_BOUNDS:   bounds = value;
            REG_FRAME_INTERVAL: interval = value[31:0];
            REG_TRANSFORM_GOOD: xform_good = value[0];
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic load_homography(logic [31:0] h00, h01, h02, h10, h11, h12,
                                   h20, h21, h22);
        write_reg(REG_COEF_PAIR_0, {h01, h00});
        write_reg(REG_COEF_PAIR_1, {h10, h02});
        write_reg(REG_COEF_PAIR_2, {h12, h11});
        write_reg(REG_COEF_PAIR_3, {h21, h20});
        write_reg(REG_COEF_LAST, {32'd0, h22});
    endtask

    // Send one pair; called at a falling edge, returns at a falling edge
    task automatic send_pair(pair_t p);
        s_prev_x = p.px;
        s_prev_y = p.py;
        s_curr_x = p.cx;
        s_curr_y = p.cy;
        s_parallax_moving = p.par;
        s_frame_end = p.fend;
        s_valid = 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        pending_results = {pending_results, classify_pair(p)};
        @(negedge aclk);
        // Idle each following cycle with the phase's probability
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid = 1'b0;
            @(negedge aclk);
        end
    endtask

    function automatic pair_t make_pair(int px, int py, int dx, int dy, bit par, bit fend);
        pair_t p;
        p.px = px;
        p.py = py;
        p.cx = px + dx;
        p.cy = py + dy;
        p.par = par;
        p.fend = fend;
        return p;
    endfunction

    // Hold until every expected result has come, then let the pipeline settle
    task automatic drain();
        s_valid = 1'b0;
        while (pending_results.size() != 0) @(negedge aclk);
        repeat (60) @(negedge aclk);
    endtask

    function automatic logic [31:0] edge_word();
        case ($urandom_range(4))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'h0;
            3: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Mostly well-formed pairs with a small motion, some noise and extremes
    function automatic pair_t random_pair();
        pair_t p;
        int sel;
        sel = $urandom_range(99);
        if (sel < 70) begin
            p = make_pair($urandom_range(67108864) - 33554432,
                          $urandom_range(67108864) - 33554432,
                          $urandom_range(800000) - 400000,
                          $urandom_range(800000) - 400000, 0, 0);
        end else if (sel < 85) begin
            p.px = $urandom;
            p.py = $urandom;
            p.cx = $urandom;
            p.cy = $urandom;
        end else begin
            p.px = edge_word();
            p.py = edge_word();
            p.cx = edge_word();
            p.cy = edge_word();
        end
        p.par = $urandom_range(1);
        p.fend = ($urandom_range(9) == 0);
        return p;
    endfunction

    // Directed: blanking, each class, extremes, zero denominator, bad interval
    task automatic test_directed();
        pair_t p;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        send_pair(make_pair(1000, 2000, 100000, 0, 1, 0));
        send_pair(make_pair(0, 0, 100000, 0, 1, 1));
        drain();
        send_pair(make_pair(0, 0, 100000, 0, 1, 1));
        drain();
        write_reg(REG_TRANSFORM_GOOD, 64'd1);
        send_pair(make_pair(5000000, -3000000, 100000, 50000, 1, 0));
        send_pair(make_pair(5000000, -3000000, 100000, 50000, 0, 0));
        send_pair(make_pair(100, 100, 0, 0, 1, 0));
        send_pair(make_pair(100, 100, 1000000, 0, 1, 0));
        p.px = 32'h7FFF_FFFF; p.py = 32'h8000_0000;
        p.cx = 32'h8000_0000; p.cy = 32'h7FFF_FFFF;
        p.par = 1; p.fend = 0;
        send_pair(p);
        send_pair(make_pair(0, 0, 0, -200000, 0, 1));
        send_pair(make_pair(0, 0, 0, -200000, 0, 1));
        drain();
        load_homography(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 0);
        send_pair(make_pair(123456, -654321, 100000, 0, 1, 0));
        send_pair(make_pair(0, 0, -50000, 50000, 1, 1));
        drain();
        load_homography(32'h0100_0000, 0, 0, 0, 32'h0100_0000, 0, 0, 0, 32'h0100_0000);
        write_reg(REG_FRAME_INTERVAL, 64'd0);
        send_pair(make_pair(0, 0, 60000, 0, 1, 0));
        drain();
        write_reg(REG_FRAME_INTERVAL, 64'hFFFF_FFFF_8000_0000);
        send_pair(make_pair(0, 0, 60000, 0, 0, 0));
        drain();
        write_reg(REG_FRAME_INTERVAL, 64'h0000_0000_7FFF_FFFF);
        send_pair(make_pair(0, 0, 32'h7FFF_FFFF, 0, 1, 0));
        drain();
        write_reg(REG_FRAME_INTERVAL, 64'd8388608);
        write_reg(REG_SPEED_BOUNDS, {32'd1000, 32'd1000000});
        send_pair(make_pair(0, 0, 100000, 0, 1, 1));
        drain();
        write_reg(REG_SPEED_BOUNDS, RST_SPEED_BOUNDS);
        write_reg(REG_FRAME_INTERVAL, RST_FRAME_INTERVAL);
    endtask

    // Pick a register setting for one random phase
    task automatic setup_config(int kind);
        case (kind)
            0: load_homography(32'h0100_0000 + $urandom_range(2000) - 1000,
                               $urandom_range(2000) - 1000, $urandom_range(20000) - 10000,
                               $urandom_range(2000) - 1000,
                               32'h0100_0000 + $urandom_range(2000) - 1000,
                               $urandom_range(20000) - 10000, 0, 0, 32'h0100_0000);
            1: load_homography(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                               32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
                               32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000);
            default: load_homography($urandom, $urandom, $urandom, $urandom, $urandom,
                                     $urandom, $urandom, $urandom, $urandom);
        endcase
        case (kind)
            0: begin
                write_reg(REG_SPEED_BOUNDS, {32'd200000 + $urandom_range(200000),
                                             32'd1000 + $urandom_range(40000)});
                write_reg(REG_FRAME_INTERVAL, 64'd8388608 + $urandom_range(25165824));
            end
            1: begin
                write_reg(REG_SPEED_BOUNDS, {32'hFFFF_FFFF, 32'd0});
                write_reg(REG_FRAME_INTERVAL, 64'h0000_0000_7FFF_FFFF);
            end
            default: begin
                write_reg(REG_SPEED_BOUNDS, {$urandom, $urandom});
                write_reg(REG_FRAME_INTERVAL, {32'd0, $urandom});
            end
        endcase
        write_reg(REG_TRANSFORM_GOOD, (kind == 3) ? 64'd0 : 64'd1);
    endtask

    // Random stream under one idle/stall pattern; optional pause to empty
    task automatic test_random(int items, int idle_pct, int stall_pct, int kind,
                               bit pause_midway);
        drain();
        setup_config(kind);
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        for (int i = 0; i < items; i++) begin
            if (pause_midway && i == items / 2) drain();
            send_pair(random_pair());
        end
    endtask

    initial begin
        coef_pair[0] = RST_COEF_PAIR_0;
        coef_pair[1] = RST_COEF_PAIR_1;
        coef_pair[2] = RST_COEF_PAIR_2;
        coef_pair[3] = RST_COEF_PAIR_3;
        coef_h22 = RST_COEF_LAST;
        bounds = RST_SPEED_BOUNDS;
        interval = RST_FRAME_INTERVAL;
        xform_good = 1'b0;
        first_frame_seen = 1'b0;
        frame_mover = 1'b0;
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);
        test_directed();
        test_random(300, 0, 0, 0, 1);
        test_random(180, 0, 0, 1, 0);
        test_random(300, 56, 0, 0, 0);
        test_random(180, 56, 0, 2, 0);
        test_random(300, 0, 56, 0, 0);
        test_random(180, 0, 56, 3, 0);
        test_random(300, 38, 38, 0, 0);
        test_random(180, 38, 38, 2, 0);
        drain();
        if (pending_results.size() != 0) errors++;
        $display("Covered %0d frames: %0d movers, %0d parallax points, %0d unclassed pairs",
                 n_frames, n_mover, n_parallax, n_none);
        $display("under directed corners, four idle/stall patterns and extreme registers");
        if (errors == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
